// ----- rtl/ukbd_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 keyboard byte decoder package
// Shared widths, the command that flows from the front end to the back end,
// and the small lookup functions for lead bytes.
// ----------------------------------------------------------------------------
package ukbd_pkg;

   localparam int KEY_WIDTH   = 16;
   localparam int CHAR_WIDTH  = 31;
   localparam int LEN_WIDTH   = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CHAR_WIDTH-1:0] NBSP_CODE  = 31'h0000_00A0;
   localparam logic [CHAR_WIDTH-1:0] SPACE_CODE = 31'h0000_0020;

   // What the back end has to do with one accepted key code.
   typedef enum logic [1:0] {
      CMD_PASS,   // emit the key code unchanged
      CMD_LEAD,   // start a sequence, no result
      CMD_CONT,   // shift in six bits, emit on the final byte
      CMD_STRAY   // emit an invalid mark
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type            kind;
      logic                    brk;         // a pending sequence was broken
      logic                    final_byte;  // continuation byte closes the sequence
      logic [LEN_WIDTH-1:0]    len;         // sequence length of a lead byte
      logic [KEY_WIDTH-1:0]    data;
   } cmd_type;

   // Number of leading ones of a lead byte in the range C0..FD.
   function automatic logic [LEN_WIDTH-1:0] lead_length(input logic [7:0] b);
      logic [LEN_WIDTH-1:0] n;
      if (!b[5]) begin
         n = 3'd2;
      end else if (!b[4]) begin
         n = 3'd3;
      end else if (!b[3]) begin
         n = 3'd4;
      end else if (!b[2]) begin
         n = 3'd5;
      end else begin
         n = 3'd6;
      end
      return n;
   endfunction

   // Payload bits that a lead byte contributes to the code point.
   function automatic logic [CHAR_WIDTH-1:0] lead_bits(input logic [7:0] b,
                                                        input logic [LEN_WIDTH-1:0] n);
      logic [CHAR_WIDTH-1:0] v;
      case (n)
         3'd2:    v = {26'd0, b[4:0]};
         3'd3:    v = {27'd0, b[3:0]};
         3'd4:    v = {28'd0, b[2:0]};
         3'd5:    v = {29'd0, b[1:0]};
         default: v = {30'd0, b[0]};
      endcase
      return v;
   endfunction

   // Smallest code point that is not overlong for a sequence length.
   function automatic logic [CHAR_WIDTH-1:0] min_for_len(input logic [LEN_WIDTH-1:0] n);
      logic [CHAR_WIDTH-1:0] v;
      case (n)
         3'd2:    v = 31'h0000_0080;
         3'd3:    v = 31'h0000_0800;
         3'd4:    v = 31'h0001_0000;
         3'd5:    v = 31'h0020_0000;
         3'd6:    v = 31'h0400_0000;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- rtl/ukbd_front.sv -----
// ----------------------------------------------------------------------------
// UTF-8 keyboard byte decoder front end
// Accepts key codes, tracks how many continuation bytes are still expected
// and turns each key code into one command for the back end.
// ----------------------------------------------------------------------------
module ukbd_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [ukbd_pkg::KEY_WIDTH-1:0]   req_key_code,
   input  logic                             csr_write_enable,
   input  logic                             csr_write_data,
   input  logic                             queue_full,
   output logic                             push_valid,
   output ukbd_pkg::cmd_type                push_cmd
);

   logic                              enable_ff, enable_in;
   logic [ukbd_pkg::LEN_WIDTH-1:0]    remaining_ff, remaining_in;
   logic                              is_byte;
   logic                              is_cont;
   logic [ukbd_pkg::LEN_WIDTH-1:0]    len;

   assign req_ready  = !queue_full;
   assign push_valid = req_valid && req_ready;

   assign is_byte = (req_key_code[ukbd_pkg::KEY_WIDTH-1:8] == '0);
   assign is_cont = enable_ff && is_byte && (req_key_code[7:6] == 2'b10);
   assign len     = ukbd_pkg::lead_length(req_key_code[7:0]);

   always_comb begin
      enable_in           = csr_write_enable ? csr_write_data : enable_ff;
      remaining_in        = remaining_ff;
      push_cmd.kind       = ukbd_pkg::CMD_PASS;
      push_cmd.brk        = 1'b0;
      push_cmd.final_byte = 1'b0;
      push_cmd.len        = len;
      push_cmd.data       = req_key_code;

      if ((remaining_ff != '0) && is_cont) begin
         push_cmd.kind       = ukbd_pkg::CMD_CONT;
         push_cmd.final_byte = (remaining_ff == 3'd1);
         remaining_in        = remaining_ff - 3'd1;
      end else begin
         push_cmd.brk = (remaining_ff != '0);
         remaining_in = '0;
         if (!is_byte || !enable_ff || !req_key_code[7]) begin
            push_cmd.kind = ukbd_pkg::CMD_PASS;
         end else if ((req_key_code[7:6] == 2'b11) && (req_key_code[7:1] != 7'h7F)) begin
            push_cmd.kind = ukbd_pkg::CMD_LEAD;
            remaining_in  = len - 3'd1;
         end else begin
            push_cmd.kind = ukbd_pkg::CMD_STRAY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         remaining_ff <= '0;
      end else begin
         enable_ff <= enable_in;
         if (push_valid) begin
            remaining_ff <= remaining_in;
         end
      end
   end

endmodule

// ----- rtl/ukbd_queue.sv -----
// ----------------------------------------------------------------------------
// UTF-8 keyboard byte decoder command queue
// A short first-in first-out store of commands between front and back end.
// ----------------------------------------------------------------------------
module ukbd_queue #(
   parameter int DEPTH = ukbd_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  ukbd_pkg::cmd_type  push_cmd,
   output logic               queue_full,
   input  logic               pop,
   output logic               head_valid,
   output ukbd_pkg::cmd_type  head_cmd
);

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   ukbd_pkg::cmd_type       mem [DEPTH];
   logic [PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]    count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign queue_full = (count_ff == CNT_WIDTH'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem[rd_ptr_ff];
   assign do_push    = push_valid && !queue_full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_WIDTH'(1);
      end
      count_in = count_ff + CNT_WIDTH'(do_push) - CNT_WIDTH'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/ukbd_back.sv -----
// ----------------------------------------------------------------------------
// UTF-8 keyboard byte decoder back end
// Carries out commands: assembles code points, checks for overlong values
// and drives the result register.
// ----------------------------------------------------------------------------
module ukbd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               head_valid,
   input  ukbd_pkg::cmd_type                  head_cmd,
   output logic                               pop,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ukbd_pkg::CHAR_WIDTH-1:0]    rsp_char_value,
   output logic                               rsp_invalid,
   output logic                               rsp_last
);

   localparam int CW = ukbd_pkg::CHAR_WIDTH;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]   rsp_char_value_ff, rsp_char_value_in;
   logic            rsp_invalid_ff, rsp_invalid_in;
   logic            rsp_last_ff, rsp_last_in;
   logic            phase_ff, phase_in;
   logic [CW-1:0]   acc_ff, acc_in;
   logic [CW-1:0]   min_ff, min_in;
   logic            load_ok;
   logic            step;
   logic            emit;
   logic [CW-1:0]   acc_shift;
   logic [CW-1:0]   lead_acc;
   logic [CW-1:0]   lead_min;

   assign load_ok   = !rsp_valid_ff || rsp_ready;
   assign step      = head_valid && load_ok;
   assign acc_shift = {acc_ff[CW-7:0], head_cmd.data[5:0]};
   assign lead_acc  = ukbd_pkg::lead_bits(head_cmd.data[7:0], head_cmd.len);
   assign lead_min  = ukbd_pkg::min_for_len(head_cmd.len);

   always_comb begin
      emit              = 1'b0;
      pop               = 1'b0;
      rsp_char_value_in = '0;
      rsp_invalid_in    = 1'b0;
      rsp_last_in       = 1'b1;
      phase_in          = phase_ff;
      acc_in            = acc_ff;
      min_in            = min_ff;

      if (step) begin
         if (head_cmd.brk && !phase_ff) begin
            // The broken sequence is reported first.
            emit           = 1'b1;
            rsp_invalid_in = 1'b1;
            if (head_cmd.kind == ukbd_pkg::CMD_LEAD) begin
               pop    = 1'b1;
               acc_in = lead_acc;
               min_in = lead_min;
            end else begin
               rsp_last_in = 1'b0;
               phase_in    = 1'b1;
            end
         end else begin
            pop      = 1'b1;
            phase_in = 1'b0;
            case (head_cmd.kind)
               ukbd_pkg::CMD_PASS: begin
                  emit              = 1'b1;
                  rsp_char_value_in = CW'(head_cmd.data);
               end
               ukbd_pkg::CMD_LEAD: begin
                  acc_in = lead_acc;
                  min_in = lead_min;
               end
               ukbd_pkg::CMD_CONT: begin
                  acc_in = acc_shift;
                  if (head_cmd.final_byte) begin
                     emit = 1'b1;
                     if (acc_shift < min_ff) begin
                        rsp_invalid_in = 1'b1;
                     end else if (acc_shift == ukbd_pkg::NBSP_CODE) begin
                        rsp_char_value_in = ukbd_pkg::SPACE_CODE;
                     end else begin
                        rsp_char_value_in = acc_shift;
                     end
                  end
               end
               default: begin
                  emit           = 1'b1;
                  rsp_invalid_in = 1'b1;
               end
            endcase
         end
      end

      rsp_valid_in = load_ok ? (step && emit) : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
         acc_ff       <= '0;
         min_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         acc_ff       <= acc_in;
         min_ff       <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && emit) begin
         rsp_char_value_ff <= rsp_char_value_in;
         rsp_invalid_ff    <= rsp_invalid_in;
         rsp_last_ff       <= rsp_last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_char_value = rsp_char_value_ff;
   assign rsp_invalid    = rsp_invalid_ff;
   assign rsp_last       = rsp_last_ff;

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_invalid_ff |-> rsp_char_value_ff == '0)
      else $error("invalid result carries a nonzero character value");

   a_phase_head: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> head_valid && head_cmd.brk && head_cmd.kind != ukbd_pkg::CMD_LEAD)
      else $error("second half of a broken sequence without a matching command");

   a_phase_first: assert property (@(posedge clock) disable iff (reset)
      $rose(phase_ff) |-> rsp_valid_ff && rsp_invalid_ff && !rsp_last_ff)
      else $error("broken sequence mark not held as a non-final invalid result");
`endif

endmodule

// ----- rtl/utf8_keyboard_byte_decoder.sv -----
// ----------------------------------------------------------------------------
// UTF-8 keyboard byte decoder
// Turns a stream of keyboard key codes into code points, decoding UTF-8
// sequences of up to six bytes when decoding is enabled.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake                      Payload
//   req      in         req_valid / req_ready          req_key_code
//   rsp      out        rsp_valid / rsp_ready          rsp_char_value, rsp_invalid,
//                                                      rsp_last
//   csr      in         csr_write_enable (no stall)    csr_write_data
//
// A key code transfer is taken in every cycle while the command queue has room.
// A key code that breaks a pending sequence without being a lead byte itself
// gives two results, the invalid mark for the break first and then its own
// (the worst case). rsp_valid is fed through the queue and the result register.
// Reset clears the decode state and the queue and turns decoding on.
// A stalled result channel fills the queue, after which req_ready drops.
//
// The front end classifies each key code against the count of continuation
// bytes still expected and pushes one command into the queue. The back end owns
// the accumulator and the overlong bound, executes the commands in order and
// holds each result in an output register, so the two sides stall separately.
module utf8_keyboard_byte_decoder #(
   parameter int QUEUE_DEPTH = ukbd_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ukbd_pkg::KEY_WIDTH-1:0]    req_key_code,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ukbd_pkg::CHAR_WIDTH-1:0]   rsp_char_value,
   output logic                              rsp_invalid,
   output logic                              rsp_last,
   input  logic                              csr_write_enable,
   input  logic                              csr_write_data
);

   logic               push_valid;
   ukbd_pkg::cmd_type  push_cmd;
   logic               queue_full;
   logic               pop;
   logic               head_valid;
   ukbd_pkg::cmd_type  head_cmd;

   // Front end: handshake, enable register and sequence length tracking.
   ukbd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_code     (req_key_code),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_cmd         (push_cmd)
   );

   // Commands wait here while the result side is stalled.
   ukbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Back end: code point assembly and the result register.
   ukbd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_char_value (rsp_char_value),
      .rsp_invalid    (rsp_invalid),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- bench/utf8_keyboard_byte_decoder_test.sv -----
// ----------------------------------------------------------------------------
// UTF-8 keyboard byte decoder testbench
// Drives key codes into the decoder with random gaps and back pressure,
// predicts every result with a behavioral decoder, and checks each result
// field by field in order. Decoding is switched on and off between phases.
// ----------------------------------------------------------------------------
package utf8_char_check_pkg;

   typedef struct {
      logic [ukbd_pkg::CHAR_WIDTH-1:0] char_value;
      logic                            invalid;
      logic                            last;
   } char_result_type;

   localparam logic [ukbd_pkg::KEY_WIDTH-1:0] ASCII_MAX = 16'h007F;
   localparam logic [ukbd_pkg::KEY_WIDTH-1:0] BYTE_MAX  = 16'h00FF;
   localparam logic [1:0]                     CONT_TAG  = 2'b10;
   localparam logic [1:0]                     LEAD_TAG  = 2'b11;

   class char_scoreboard;
      bit                              decode_on  = 1'b1;
      logic [2:0]                      cont_left  = '0;
      logic [ukbd_pkg::CHAR_WIDTH-1:0] code_acc   = '0;
      logic [ukbd_pkg::CHAR_WIDTH-1:0] code_floor = '0;
      char_result_type                 expected_chars[$];
      int unsigned                     keys_noted;
      int unsigned                     chars_checked;
      int unsigned                     invalid_marks;
      int unsigned                     failures;

      function void set_decode(bit on);
         decode_on = on;
      endfunction

      function int unsigned pending();
         return expected_chars.size();
      endfunction

      function void emit(logic [ukbd_pkg::CHAR_WIDTH-1:0] value, logic bad);
         char_result_type r;
         r.char_value = value;
         r.invalid    = bad;
         r.last       = 1'b0;
         expected_chars.push_back(r);
      endfunction

      // Predicts the results of one accepted key code and updates the
      // decode state the same way the block does.
      function void note_key(logic [ukbd_pkg::KEY_WIDTH-1:0] key);
         logic [7:0]      b;
         int unsigned     first;
         int unsigned     len;
         char_result_type tail;
         b     = key[7:0];
         first = expected_chars.size();
         keys_noted++;
         if (cont_left != 0 && decode_on && key <= BYTE_MAX && b[7:6] == CONT_TAG) begin
            code_acc  = {code_acc[ukbd_pkg::CHAR_WIDTH-7:0], b[5:0]};
            cont_left = cont_left - 3'd1;
            if (cont_left == 0) begin
               if (code_acc < code_floor) begin
                  emit('0, 1'b1);
               end else if (code_acc == ukbd_pkg::NBSP_CODE) begin
                  emit(ukbd_pkg::SPACE_CODE, 1'b0);
               end else begin
                  emit(code_acc, 1'b0);
               end
            end
         end else begin
            // Anything but a continuation byte drops a pending sequence.
            if (cont_left != 0) begin
               cont_left = '0;
               emit('0, 1'b1);
            end
            if (key <= ASCII_MAX || key > BYTE_MAX || !decode_on) begin
               emit(ukbd_pkg::CHAR_WIDTH'(key), 1'b0);
            end else if (b[7:6] == LEAD_TAG && b[7:1] != 7'h7F) begin
               casez (b[5:1])
                  5'b0????: len = 2;
                  5'b10???: len = 3;
                  5'b110??: len = 4;
                  5'b1110?: len = 5;
                  default:  len = 6;
               endcase
               cont_left = 3'(len - 1);
               code_acc  = ukbd_pkg::CHAR_WIDTH'(b & (8'hFF >> (len + 1)));
               case (len)
                  2:       code_floor = 31'h0000_0080;
                  3:       code_floor = 31'h0000_0800;
                  4:       code_floor = 31'h0001_0000;
                  5:       code_floor = 31'h0020_0000;
                  default: code_floor = 31'h0400_0000;
               endcase
            end else begin
               emit('0, 1'b1);
            end
         end
         if (expected_chars.size() > first) begin
            tail      = expected_chars.pop_back();
            tail.last = 1'b1;
            expected_chars.push_back(tail);
         end
      endfunction

      function void check_char(logic [ukbd_pkg::CHAR_WIDTH-1:0] value, logic bad,
                               logic last);
         char_result_type want;
         chars_checked++;
         if (bad) invalid_marks++;
         if (expected_chars.size() == 0) begin
            $error("unexpected result: char_value %h invalid %b last %b", value, bad, last);
            failures++;
            return;
         end
         want = expected_chars.pop_front();
         if (value !== want.char_value) begin
            $error("char_value: expected %h, actual %h", want.char_value, value);
            failures++;
         end
         if (bad !== want.invalid) begin
            $error("invalid: expected %b, actual %b", want.invalid, bad);
            failures++;
         end
         if (last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, last);
            failures++;
         end
      endfunction
   endclass
endpackage

module utf8_keyboard_byte_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KW = ukbd_pkg::KEY_WIDTH;
   localparam int CW = ukbd_pkg::CHAR_WIDTH;

   // Quiet cycles with no transfer on either channel before the run is
   // declared hung. Gaps and stalls, as pick_gap sets them, are far shorter.
   localparam int unsigned QUIET_LIMIT   = 5000;
   // Cycles to let pass once nothing is expected, so that a lead byte still
   // in the command queue has reached the back end before a register write.
   localparam int unsigned SETTLE_CYCLES = 12;

   logic            clock            = 1'b0;
   logic            reset            = 1'b1;
   logic            req_valid        = 1'b0;
   logic            req_ready;
   logic [KW-1:0]   req_key_code     = '0;
   logic            rsp_valid;
   logic            rsp_ready        = 1'b0;
   logic [CW-1:0]   rsp_char_value;
   logic            rsp_invalid;
   logic            rsp_last;
   logic            csr_write_enable = 1'b0;
   logic            csr_write_data   = 1'b0;

   // Stretches in which a side never idles; rerolled now and then.
   logic            steady_req       = 1'b0;
   logic            steady_rsp       = 1'b0;

   utf8_char_check_pkg::char_scoreboard board;
   int unsigned     decode_writes    = 0;
   int unsigned     ready_hold       = 0;
   int unsigned     quiet_cycles     = 0;

   utf8_keyboard_byte_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_key_code     (req_key_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_value   (rsp_char_value),
      .rsp_invalid      (rsp_invalid),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idle lengths: mostly none, often short, now and then a long one.
   function automatic int unsigned pick_gap(input logic steady);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // The result side toggles rsp_ready between ready runs and stalls. All
   // inputs change only through nonblocking assignments at the rising edge,
   // so the block and the monitor below both see the values from before it.
   always @(posedge clock) begin
      if (steady_rsp) begin
         rsp_ready  <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if (rsp_ready) begin
         rsp_ready  <= 1'b0;
         ready_hold <= pick_gap(1'b0);
      end else begin
         rsp_ready  <= 1'b1;
         ready_hold <= $urandom_range(0, 12);
      end
   end

   // Every result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_char(rsp_char_value, rsp_invalid, rsp_last);
      end
   end

   // Watchdog: a run in which nothing moves for too long has hung.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offers one key code and holds it until the transfer happens. Valid is
   // left high when the next key code follows at once, so that it is never
   // lowered and raised within the same time step.
   task automatic send_key(input logic [KW-1:0] key);
      int unsigned gap;
      req_valid    <= 1'b1;
      req_key_code <= key;
      do @(posedge clock); while (!req_ready);
      board.note_key(key);
      gap = pick_gap(steady_req);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds the sender back until every predicted result has arrived, then
   // lets the block settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The enable register is only written while the block is idle. A pending
   // sequence survives the write, which is how switching decoding off in the
   // middle of a sequence gets exercised.
   task automatic write_decode(input logic on);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= on;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_decode(on);
      decode_writes++;
   endtask

   // Sends a lead byte for a sequence of the given length with random payload
   // bits, followed by the given number of continuation bytes. A length of
   // one sends a plain ASCII byte. Lead bytes near the bottom of each range
   // make overlong values likely enough to show up often.
   task automatic send_utf8(input int unsigned len, input int unsigned conts);
      logic [7:0] lead;
      if (len <= 1) begin
         send_key(KW'($urandom_range(0, utf8_char_check_pkg::ASCII_MAX)));
         return;
      end
      case (len)
         2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
         3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
         4:       lead = 8'($urandom_range(8'hF0, 8'hF7));
         5:       lead = 8'($urandom_range(8'hF8, 8'hFB));
         default: lead = 8'($urandom_range(8'hFC, 8'hFD));
      endcase
      send_key({8'h00, lead});
      repeat (conts) send_key({8'h00, utf8_char_check_pkg::CONT_TAG, 6'($urandom)});
   endtask

   // Mostly well-formed sequences, the rest cut-off sequences, stray high
   // bytes and fully random key codes (which include the special keys).
   task automatic send_random_item();
      int unsigned pick;
      int unsigned len;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         len = $urandom_range(1, 6);
         send_utf8(len, len - 1);
      end else if (pick < 80) begin
         len = $urandom_range(2, 6);
         send_utf8(len, $urandom_range(0, len - 2));
      end else if (pick < 90) begin
         send_key(KW'($urandom_range(16'h0080, 16'h00FF)));
      end else begin
         send_key(KW'($urandom_range(0, 16'hFFFF)));
      end
   endtask

   task automatic run_random(input int unsigned count);
      int unsigned stop;
      stop = board.keys_noted + count;
      while (board.keys_noted < stop) begin
         if ($urandom_range(0, 19) == 0) begin
            steady_req <= ($urandom_range(0, 3) == 0);
            steady_rsp <= ($urandom_range(0, 3) == 0);
         end
         send_random_item();
      end
   endtask

   initial begin
      board = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_decode(1'b1);

      // Smallest and largest key codes pass straight through.
      send_key(16'h0000);
      send_key(16'hFFFF);
      // A decoded no-break space comes out as a plain space.
      send_key(16'h00C2);
      send_key(16'h00A0);
      // Overlong two-byte form of zero.
      send_key(16'h00C0);
      send_key(16'h0080);
      // Six-byte sequence with every payload bit set: the largest value.
      send_key(16'h00FD);
      repeat (5) send_key(16'h00BF);
      // Stray continuation byte, then the two bytes that can never lead.
      send_key(16'h0080);
      send_key(16'h00FE);
      send_key(16'h00FF);
      // Sequence broken by an ASCII byte, which is then passed through.
      send_key(16'h00E2);
      send_key(16'h0041);
      // Sequence broken by a special key.
      send_key(16'h00F0);
      send_key(16'h009F);
      send_key(16'h1234);
      // Sequence broken by switching decoding off; the following 0xA0 is
      // passed through unchanged rather than turned into a space.
      send_key(16'h00C3);
      write_decode(1'b0);
      send_key(16'h00A0);
      write_decode(1'b1);

      // Random phases, with decoding on, off and on again. The pause in the
      // middle of the first phase lets the whole pipeline drain.
      run_random(500);
      drain_results();
      run_random(450);
      write_decode(1'b0);
      run_random(250);
      write_decode(1'b1);
      run_random(750);

      drain_results();
      $display("Run covered %0d key code transfers and %0d result transfers, %0d invalid.",
               board.keys_noted, board.chars_checked, board.invalid_marks);
      $display("Decode enable was written %0d times, switching decoding off and on.",
               decode_writes);
      if (board.failures == 0 && board.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
